### hdl/tmsh_pkg.sv
// package: widths, multiplier constant and substitution table of the string hash
`default_nettype none

package tmsh_pkg;

  // field widths
  localparam int DATA_W         = 8;
  localparam int LEN_W          = 32;
  localparam int OUT_W          = 64;
  localparam int POS_W          = 8;

  // default accumulator width and multiplier
  localparam int HASH_WIDTH_DEF = 64;
  localparam int HASH_MULT      = 1717;

  // byte substitution table, indexed by byte plus position
  localparam logic [7:0] SUBST_TAB [256] = '{
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

endpackage

`default_nettype wire

### hdl/table_multiply_string_hash.sv
// top level: byte-serial table/multiply string hash with registered result
`default_nettype none

// Hashes a byte string delivered one byte per input transfer. The first byte
// seeds the accumulator with in_string_len and clears the position; each byte
// XORs in a table entry picked by (byte + position) mod 256, then the
// accumulator is multiplied by 1717 modulo 2^HASH_WIDTH. The transfer that
// carries in_last_byte produces one result; an in_empty_string transfer
// produces hash 0 and clears the state. One byte is taken every cycle while
// the result side keeps up; in_ready drops only while an untaken result sits
// in the output register and the item in the second stage would produce
// another, and it follows out_ready in the same cycle. out_valid rises after
// the last byte has passed the first stage, which does the synchronous table
// read, and the second, which applies the xor and constant multiply, closing
// the accumulator loop combinationally, and loads the output register.
// Result bits at and above HASH_WIDTH are zero.
module table_multiply_string_hash
  import tmsh_pkg::*;
#(
  parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [DATA_W-1:0]  in_data_byte,
  input  wire  [LEN_W-1:0]   in_string_len,
  input  wire                in_first_byte,
  input  wire                in_last_byte,
  input  wire                in_empty_string,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [OUT_W-1:0]   out_hash_value
);

  // stage 0 position counter
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_eff;
  logic [POS_W-1:0]      pos_nxt;
  logic [POS_W-1:0]      tab_idx;

  // stage 1 registers
  logic                  v1_r;
  logic                  first1_r;
  logic                  last1_r;
  logic                  empty1_r;
  logic [LEN_W-1:0]      len1_r;
  logic [7:0]            tab1_r;

  // accumulator and output register
  logic [HASH_WIDTH-1:0] acc_r;
  logic [HASH_WIDTH-1:0] acc_nxt;
  logic [HASH_WIDTH-1:0] acc_seed;
  logic [HASH_WIDTH-1:0] acc_mix;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_hash_r;

  logic                  in_xfer;
  logic                  emits1;
  logic                  stall1;
  logic                  commit1;

  // handshake and pipeline control
  assign emits1   = last1_r | empty1_r;
  assign stall1   = v1_r & emits1 & out_valid_r & ~out_ready;
  assign commit1  = v1_r & ~stall1;
  assign in_ready = ~stall1;
  assign in_xfer  = in_valid & in_ready;

  // table index from byte plus position
  assign pos_eff = in_first_byte ? '0 : pos_r;
  assign tab_idx = in_data_byte + pos_eff;
  assign pos_nxt = in_empty_string ? '0 : pos_eff + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_xfer) begin
      pos_r <= pos_nxt;
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  // synchronous table read and item flags
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tab1_r   <= SUBST_TAB[tab_idx];
      first1_r <= in_first_byte;
      last1_r  <= in_last_byte;
      empty1_r <= in_empty_string;
      len1_r   <= in_string_len;
    end
  end

  // accumulator update: seed, xor table entry, multiply
  assign acc_seed = first1_r ? HASH_WIDTH'(len1_r) : acc_r;
  assign acc_mix  = acc_seed ^ HASH_WIDTH'(tab1_r);
  assign acc_nxt  = empty1_r ? '0 : HASH_WIDTH'(acc_mix * HASH_WIDTH'(HASH_MULT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (commit1) begin
      acc_r <= acc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit1 && emits1) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit1 && emits1) begin
      out_hash_r <= OUT_W'(acc_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // checks
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stall1 |-> !in_ready)
    else $error("input taken while result stage is stalled");

  a_empty_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (commit1 && empty1_r) |=> (out_valid && out_hash_value == '0 && acc_r == '0))
    else $error("empty string did not give hash zero");

  a_empty_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_empty_string) |=> (pos_r == '0))
    else $error("empty string did not clear position");

  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_first_byte && !in_empty_string) |=> (pos_r == POS_W'(1)))
    else $error("first byte did not restart position");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_hash_value >> HASH_WIDTH) == '0))
    else $error("hash bits above accumulator width are set");

endmodule

`default_nettype wire

### dv/testbench.sv
// testbench: drives byte strings into the string hash and checks each result against a predictor
`timescale 1ns / 100ps

module testbench
  import tmsh_pkg::*;
();

  localparam logic [63:0] HASH_MASK = {64{1'b1}} >> (64 - HASH_WIDTH_DEF);
  localparam int RANDOM_ITEMS    = 800;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 8;

  // running hash predictor plus the queue of hashes still owed by the block
  class hash_scoreboard;
    logic [63:0] acc;
    logic [7:0]  pos;
    logic [63:0] expected_hashes[$];
    int          errors;
    int          hashes_checked;
    int          empties_seen;

    function new();
      acc = '0;
      pos = '0;
      errors = 0;
      hashes_checked = 0;
      empties_seen = 0;
    endfunction

    // fold one accepted byte into the predicted state
    function void note_byte(logic [DATA_W-1:0] data, logic [LEN_W-1:0] len,
                            logic first, logic last, logic is_empty);
      logic [7:0] idx;
      if (is_empty) begin
        acc = '0;
        pos = '0;
        empties_seen++;
        expected_hashes = {expected_hashes, 64'd0};
        return;
      end
      if (first) begin
        acc = {{(64-LEN_W){1'b0}}, len} & HASH_MASK;
        pos = '0;
      end
      idx = data + pos;
      acc = ((acc ^ {56'b0, SUBST_TAB[idx]}) * 64'(HASH_MULT)) & HASH_MASK;
      pos = pos + 8'd1;
      if (last) expected_hashes = {expected_hashes, acc};
    endfunction

    // compare one result transfer with the oldest owed hash
    function void check_hash(logic [OUT_W-1:0] actual);
      logic [63:0] want;
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected result, actual hash %h", $time, actual);
        errors++;
        return;
      end
      want = expected_hashes.pop_front();
      hashes_checked++;
      if (actual !== want) begin
        $display("%0t: hash mismatch, expected %h actual %h", $time, want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [DATA_W-1:0]  in_data_byte;
  logic [LEN_W-1:0]   in_string_len;
  logic               in_first_byte;
  logic               in_last_byte;
  logic               in_empty_string;
  logic               out_valid;
  logic               out_ready;
  logic [OUT_W-1:0]   out_hash_value;

  hash_scoreboard sb;
  int  items_sent;
  int  burst_left;
  int  quiet_cycles;
  int  long_strings;
  bit  hold_off_req;

  table_multiply_string_hash uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_string_len   (in_string_len),
    .in_first_byte   (in_first_byte),
    .in_last_byte    (in_last_byte),
    .in_empty_string (in_empty_string),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value)
  );

  always #2 clk = ~clk;

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_byte(in_data_byte, in_string_len, in_first_byte, in_last_byte,
                     in_empty_string);
      if (out_valid && out_ready) sb.check_hash(out_hash_value);
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d hashes still owed", $time, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: stretches of steady ready, random stalls and a sparse pattern
  initial begin : receiver
    int mode;
    int span;
    int k;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(1, 40);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_off_req) break;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (k % 4 == 0);
        endcase
      end
    end
  end

  // offer one byte and hold it until the transfer
  task automatic send_item(logic [DATA_W-1:0] data, logic [LEN_W-1:0] len,
                           logic first, logic last, logic is_empty);
    in_valid        <= 1'b1;
    in_data_byte    <= data;
    in_string_len   <= len;
    in_first_byte   <= first;
    in_last_byte    <= last;
    in_empty_string <= is_empty;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
    pace();
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // burst bookkeeping: a random gap once a burst runs out
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic send_string(int n, logic [LEN_W-1:0] len);
    int i;
    for (i = 0; i < n; i++)
      send_item(DATA_W'($urandom), len, i == 0, i == n - 1, 1'b0);
  endtask

  // stop offering until every owed hash has come back
  task automatic drain_results();
    sender_gap(1);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int  kind;
    int  n;
    bit  held;
    bit  paused;
    logic [LEN_W-1:0] len;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data_byte    = '0;
    in_string_len   = '0;
    in_first_byte   = 1'b0;
    in_last_byte    = 1'b0;
    in_empty_string = 1'b0;
    out_ready       = 1'b0;
    hold_off_req    = 1'b0;
    quiet_cycles    = 0;
    items_sent      = 0;
    long_strings    = 0;
    burst_left      = 5;
    held            = 1'b0;
    paused          = 1'b0;
    sb = new();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // byte with no first marker straight after reset
    send_item(8'h00, 32'h0, 1'b0, 1'b1, 1'b0);
    // empty string wins over every other flag
    send_item(8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1);
    // one-byte strings at both extremes
    send_item(8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 32'h0, 1'b1, 1'b1, 1'b0);
    // short well-formed string
    send_item(8'h00, 32'd4, 1'b1, 1'b0, 1'b0);
    send_item(8'hff, 32'd4, 1'b0, 1'b0, 1'b0);
    send_item(8'h80, 32'd4, 1'b0, 1'b0, 1'b0);
    send_item(8'h7f, 32'd4, 1'b0, 1'b1, 1'b0);
    // length field disagrees with the bytes sent
    send_item(8'ha5, 32'h8000_0001, 1'b1, 1'b0, 1'b0);
    send_item(8'h5a, 32'h8000_0001, 1'b0, 1'b0, 1'b0);
    send_item(8'h01, 32'h8000_0001, 1'b0, 1'b1, 1'b0);
    // bytes continuing after a last byte, no first marker
    send_item(8'h3c, 32'h0, 1'b0, 1'b0, 1'b0);
    send_item(8'hc3, 32'h0, 1'b0, 1'b1, 1'b0);
    // empty string landing in the middle of a string
    send_item(8'h11, 32'd3, 1'b1, 1'b0, 1'b0);
    send_item(8'h55, 32'h1234_5678, 1'b0, 1'b0, 1'b1);
    send_item(8'h22, 32'd3, 1'b0, 1'b1, 1'b0);
    // a second first marker restarts the string
    send_item(8'h01, 32'd2, 1'b1, 1'b0, 1'b0);
    send_item(8'h02, 32'd2, 1'b1, 1'b0, 1'b0);
    send_item(8'h03, 32'd2, 1'b0, 1'b1, 1'b0);
    send_item(8'h00, 32'h0, 1'b0, 1'b0, 1'b1);

    // random part: mostly well-formed strings, some empties and noise
    n = items_sent;
    while (items_sent < n + RANDOM_ITEMS) begin
      if (!held && items_sent > n + 250) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      if (!paused && items_sent > n + 500) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (long_strings == 0 && items_sent > n + 150) begin
        // position counter wraps once
        send_string(270, 32'd270);
        long_strings++;
      end else if (kind < 70) begin
        kind = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
        len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom) : LEN_W'(kind);
        send_string(kind, len);
      end else if (kind < 82) begin
        send_item(DATA_W'($urandom), LEN_W'($urandom), 1'($urandom),
                  1'($urandom), 1'b1);
      end else begin
        send_item(DATA_W'($urandom), LEN_W'($urandom), 1'($urandom),
                  1'($urandom), $urandom_range(0, 9) == 0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d byte transfers, %0d hashes checked, %0d of them empty strings",
             items_sent, sb.hashes_checked, sb.empties_seen);
    $display("included %0d strings past the 256-byte position wrap, one long receiver hold",
             long_strings);
    if (sb.pending() != 0)
      $display("%0t: %0d hashes never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
